// ===== design/gds_pkg.sv =====
// Shared types, constants and calendar helpers for the Gregorian date stepper.
// Used by gds_ctrl, gds_datapath and gregorian_date_stepper_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gds_pkg;

    // Field widths.
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 10;
    localparam int CMD_W   = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FORWARD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BACK    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd3;

    // Bounds of the stepper.
    localparam logic [YEAR_W-1:0]  MAX_YEAR = 14'd9999;
    localparam logic [COUNT_W-1:0] MAX_STEP = 10'd1023;

    // Calendar constants.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAYS_28   = 5'd28;
    localparam logic [DAY_W-1:0]   DAYS_29   = 5'd29;
    localparam logic [DAY_W-1:0]   DAYS_30   = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_31   = 5'd31;

    // Division of a year by 100 as a multiplication by a reciprocal.
    // floor(y * 5243 / 2^19) equals floor(y / 100) for every 14-bit year.
    localparam int              RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int              RECIP_SHIFT = 19;
    localparam int              PROD_W      = YEAR_W + RECIP_W;
    localparam int              CENT_W      = PROD_W - RECIP_SHIFT;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // take a new request
        logic eval;     // latch validity and the first refusal check
        logic step;     // move the working date by one day
        logic commit;   // copy the working date to the stored date
        logic fail;     // a step left the year bounds
        logic emit;     // load the output register
    } gds_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             cnt_zero;
        logic             start_ok;
        logic             yr_change;
        logic             step_fail;
    } gds_stat_t;

    // Length of a month; months outside 1..12 report 31, as in the calendar rules.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MONTH_FEB:                               len = leap ? DAYS_29 : DAYS_28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_30;
            default:                                 len = DAYS_31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== design/gds_datapath.sv =====
// Datapath of the date stepper: stored and working dates, leap-year unit,
// one-day step logic, step counter and output register. Depends on gds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gds_datapath (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire  [gds_pkg::CMD_W-1:0]   command,
    input  wire  [gds_pkg::DAY_W-1:0]   load_day,
    input  wire  [gds_pkg::MONTH_W-1:0] load_month,
    input  wire  [gds_pkg::YEAR_W-1:0]  load_year,
    input  wire  [gds_pkg::COUNT_W-1:0] day_count,
    input  wire  gds_pkg::gds_ctl_t     ctl,
    output gds_pkg::gds_stat_t          stat,
    output logic [gds_pkg::DAY_W-1:0]   cur_day,
    output logic [gds_pkg::MONTH_W-1:0] cur_month,
    output logic [gds_pkg::YEAR_W-1:0]  cur_year,
    output logic                        date_valid,
    output logic                        range_error
);

    import gds_pkg::*;

    logic [DAY_W-1:0]   day_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [DAY_W-1:0]   wday_reg;
    logic [MONTH_W-1:0] wmon_reg;
    logic [YEAR_W-1:0]  wyear_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [CENT_W-1:0]  cent_reg;
    logic               valid_flag_reg;
    logic               err_flag_reg;

    logic [PROD_W-1:0]  prod;
    logic [YEAR_W:0]    hundred;
    logic               whole_century;
    logic               leap;
    logic [DAY_W-1:0]   mlen;
    logic [DAY_W-1:0]   prev_len;
    logic [MONTH_W-1:0] prev_month;
    logic               date_ok;
    logic               start_ok;
    logic [COUNT_W-1:0] count_sat;

    logic [DAY_W-1:0]   wday_next;
    logic [MONTH_W-1:0] wmon_next;
    logic [YEAR_W-1:0]  wyear_next;
    logic               yr_change;
    logic               step_fail;

    // Century number of the working year; registered after the multiplier.
    assign prod = PROD_W'(wyear_reg) * PROD_W'(RECIP_100);

    always_ff @(posedge clk)
    begin
        cent_reg <= prod[PROD_W-1:RECIP_SHIFT];
    end

    // Leap year: divisible by 4, and not a whole century unless divisible by 400.
    assign hundred = {1'b0, cent_reg, 6'b0} + {2'b0, cent_reg, 5'b0}
                   + {5'b0, cent_reg, 2'b0};
    assign whole_century = (hundred == {1'b0, wyear_reg});
    assign leap = (wyear_reg[1:0] == 2'b00) && (!whole_century || (cent_reg[1:0] == 2'b00));

    // Month lengths and validity of the working date.
    assign mlen       = month_len(wmon_reg, leap);
    assign prev_month = wmon_reg - MONTH_JAN;
    assign prev_len   = month_len(prev_month, leap);
    assign date_ok    = (wyear_reg != '0) && (wmon_reg != '0) && (wmon_reg <= MONTH_DEC)
                      && (wday_reg != '0) && (wday_reg <= mlen);
    assign start_ok   = date_ok && (wyear_reg <= MAX_YEAR);
    assign count_sat  = (day_count > MAX_STEP) ? MAX_STEP : day_count;

    // One day forward or back from the working date.
    always_comb
    begin
        wday_next  = wday_reg;
        wmon_next  = wmon_reg;
        wyear_next = wyear_reg;
        yr_change  = 1'b0;
        step_fail  = 1'b0;
        if (cmd_reg == CMD_FORWARD)
        begin
            if (wday_reg < mlen)
            begin
                wday_next = wday_reg + DAY_FIRST;
            end
            else if (wmon_reg < MONTH_DEC)
            begin
                wday_next = DAY_FIRST;
                wmon_next = wmon_reg + MONTH_JAN;
            end
            else if (wyear_reg >= MAX_YEAR)
            begin
                step_fail = 1'b1;
            end
            else
            begin
                wday_next  = DAY_FIRST;
                wmon_next  = MONTH_JAN;
                wyear_next = wyear_reg + YEAR_W'(1);
                yr_change  = 1'b1;
            end
        end
        else
        begin
            if (wday_reg > DAY_FIRST)
            begin
                wday_next = wday_reg - DAY_FIRST;
            end
            else if (wmon_reg > MONTH_JAN)
            begin
                wmon_next = prev_month;
                wday_next = prev_len;
            end
            else if (wyear_reg == '0)
            begin
                step_fail = 1'b1;
            end
            else
            begin
                wday_next  = DAYS_31;
                wmon_next  = MONTH_DEC;
                wyear_next = wyear_reg - YEAR_W'(1);
                yr_change  = 1'b1;
            end
        end
    end

    // Stored date: written by a load request or by a successful step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg   <= '0;
            month_reg <= '0;
            year_reg  <= '0;
        end
        else if (ctl.accept && (command == CMD_LOAD))
        begin
            day_reg   <= load_day;
            month_reg <= load_month;
            year_reg  <= load_year;
        end
        else if (ctl.commit)
        begin
            day_reg   <= wday_reg;
            month_reg <= wmon_reg;
            year_reg  <= wyear_reg;
        end
    end

    // Working date, request fields and step counter.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg <= command;
            cnt_reg <= count_sat;
            if (command == CMD_LOAD)
            begin
                wday_reg  <= load_day;
                wmon_reg  <= load_month;
                wyear_reg <= load_year;
            end
            else
            begin
                wday_reg  <= day_reg;
                wmon_reg  <= month_reg;
                wyear_reg <= year_reg;
            end
        end
        else if (ctl.step)
        begin
            wday_reg  <= wday_next;
            wmon_reg  <= wmon_next;
            wyear_reg <= wyear_next;
            cnt_reg   <= cnt_reg - COUNT_W'(1);
        end
    end

    // Result flags.
    always_ff @(posedge clk)
    begin
        if (ctl.eval)
        begin
            valid_flag_reg <= date_ok;
            err_flag_reg   <= ((cmd_reg == CMD_FORWARD) || (cmd_reg == CMD_BACK)) && !start_ok;
        end
        else if (ctl.commit)
        begin
            valid_flag_reg <= date_ok;
        end
        else if (ctl.fail)
        begin
            err_flag_reg <= 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            cur_day     <= day_reg;
            cur_month   <= month_reg;
            cur_year    <= year_reg;
            date_valid  <= valid_flag_reg;
            range_error <= err_flag_reg;
        end
    end

    assign stat.command   = cmd_reg;
    assign stat.cnt_zero  = (cnt_reg == '0);
    assign stat.start_ok  = start_ok;
    assign stat.yr_change = yr_change;
    assign stat.step_fail = step_fail;

endmodule

`default_nettype wire

// ===== design/gds_ctrl.sv =====
// Controller of the date stepper: sequences request intake, leap-year settling,
// day stepping and result hand-over. Depends on gds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gds_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire                     out_stall,
    input  wire gds_pkg::gds_stat_t stat,
    output gds_pkg::gds_ctl_t       ctl
);

    import gds_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_EVAL   = 3'd2;
    localparam logic [2:0] ST_STEP   = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;
    logic       is_step_cmd;

    assign slot_free   = !out_valid_reg || !out_stall;
    assign is_step_cmd = (stat.command == CMD_FORWARD) || (stat.command == CMD_BACK);
    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;

    // Next state and commands to the datapath.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // The century register settles on the new working year here.
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                ctl.eval   = 1'b1;
                state_next = (is_step_cmd && stat.start_ok) ? ST_STEP : ST_FINISH;
            end
            ST_STEP:
            begin
                if (stat.cnt_zero)
                begin
                    ctl.commit = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (stat.step_fail)
                begin
                    ctl.fail   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    ctl.step   = 1'b1;
                    state_next = stat.yr_change ? ST_WAIT : ST_STEP;
                end
            end
            ST_WAIT:
            begin
                // A new year waits here for the century register, and so its leap flag, to settle.
                state_next = ST_STEP;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid follows the output register.
    always_comb
    begin
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/gregorian_date_stepper_core.sv =====
// Top level of the Gregorian date stepper: joins the controller and the datapath.
// Depends on gds_pkg, gds_ctrl and gds_datapath.
//
//   Channel   Handshake             Payload
//   request   in_valid / in_stall   command, load_day, load_month, load_year, day_count
//   result    out_valid / out_stall cur_day, cur_month, cur_year, date_valid, range_error
//
// A load or report request, or a step refused at the start, passes through the states
// ST_IDLE, ST_PREP, ST_EVAL and ST_FINISH in that order. A step that runs also stays in
// ST_STEP while days are stepped, with a pass through ST_WAIT at each year boundary.
// The one-day step unit sets a step's run time: one day a cycle, bar each ST_WAIT pass.
// Reset clears the stored date to zero and empties the output register.
// A finished result waits in the output register while out_stall is high;
// a new request is taken as soon as the previous one has been handed over to it.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_stepper_core (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire  [gds_pkg::CMD_W-1:0]   command,
    input  wire  [gds_pkg::DAY_W-1:0]   load_day,
    input  wire  [gds_pkg::MONTH_W-1:0] load_month,
    input  wire  [gds_pkg::YEAR_W-1:0]  load_year,
    input  wire  [gds_pkg::COUNT_W-1:0] day_count,
    output logic                        out_valid,
    input  wire                         out_stall,
    output logic [gds_pkg::DAY_W-1:0]   cur_day,
    output logic [gds_pkg::MONTH_W-1:0] cur_month,
    output logic [gds_pkg::YEAR_W-1:0]  cur_year,
    output logic                        date_valid,
    output logic                        range_error
);

    import gds_pkg::*;

    gds_ctl_t  ctl;
    gds_stat_t stat;

    // Sequencer.
    gds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Date registers and step logic.
    gds_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .load_day    (load_day),
        .load_month  (load_month),
        .load_year   (load_year),
        .day_count   (day_count),
        .ctl         (ctl),
        .stat        (stat),
        .cur_day     (cur_day),
        .cur_month   (cur_month),
        .cur_year    (cur_year),
        .date_valid  (date_valid),
        .range_error (range_error)
    );

    // A waiting result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !ctl.emit)
        else $error("output register overwritten while stalled");

    // A day is only stepped while the count is not exhausted.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> !stat.cnt_zero)
        else $error("step issued with zero count");

    // A step request ends either committed or refused, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.commit && ctl.fail))
        else $error("commit and refusal in the same cycle");

    // After a request is taken, the next one is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while busy");

endmodule

`default_nettype wire
